[src/lsoc_pkg.sv]
// Package: shared types, constants and tables for the lidar scan clusterer.
package lsoc_pkg;

    localparam int unsigned MIN_RANGE_MM   = 100;
    localparam int unsigned CLUSTER_GAP_MM = 500;
    localparam int unsigned MATE_RADIUS_MM = 450;
    localparam logic [47:0] MATE_RR        = 48'(MATE_RADIUS_MM * MATE_RADIUS_MM);

    localparam int unsigned CORDIC_STEPS = 16;
    localparam logic signed [17:0] CORDIC_X0 = 18'sd19898;
    localparam logic signed [17:0] Q15_MAX   = 18'sd32767;

    // register indexes
    localparam logic [2:0] REG_SELF_X    = 3'd0;
    localparam logic [2:0] REG_SELF_Y    = 3'd1;
    localparam logic [2:0] REG_HEADING   = 3'd2;
    localparam logic [2:0] REG_MATE_A_X  = 3'd3;
    localparam logic [2:0] REG_MATE_A_Y  = 3'd4;
    localparam logic [2:0] REG_MATE_B_X  = 3'd5;
    localparam logic [2:0] REG_MATE_B_Y  = 3'd6;
    localparam logic [2:0] REG_RANGE_LIM = 3'd7;

    localparam logic KIND_CLUSTER = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [15:0] range_mm;
        logic [15:0] beam_angle;
        logic        invalid;
        logic        scan_end;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic signed [19:0] obstacle_x;
        logic signed [19:0] obstacle_y;
        logic [15:0]        obstacle_range;
        logic [15:0]        nearest_range;
        logic [15:0]        nearest_angle;
        logic               last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item
        logic cordic_go;  // start rotation
        logic proj;       // project to world
        logic mate_sq;    // square distances
        logic decide;     // compute teammate verdict
        logic update;     // update cluster / scan state
        logic clear;      // end of scan reset
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic keep;       // range window pass
        logic cordic_done;
        logic clear_mate; // not near either teammate
        logic gap_emit;   // gap closes an open cluster
        logic open;       // cluster open (after update)
        logic scan_end;
    } t_sts;

    // atan(2^-i) in 2^32 per turn, truncated to 33 bits plus sign
    function automatic logic signed [33:0] atan_lut(input logic [3:0] i);
        unique case (i)
            4'd0:  atan_lut = 34'sd536870912;
            4'd1:  atan_lut = 34'sd316933406;
            4'd2:  atan_lut = 34'sd167458907;
            4'd3:  atan_lut = 34'sd85004756;
            4'd4:  atan_lut = 34'sd42667331;
            4'd5:  atan_lut = 34'sd21354465;
            4'd6:  atan_lut = 34'sd10679838;
            4'd7:  atan_lut = 34'sd5340245;
            4'd8:  atan_lut = 34'sd2670163;
            4'd9:  atan_lut = 34'sd1335087;
            4'd10: atan_lut = 34'sd667544;
            4'd11: atan_lut = 34'sd333772;
            4'd12: atan_lut = 34'sd166886;
            4'd13: atan_lut = 34'sd83443;
            4'd14: atan_lut = 34'sd41722;
            default: atan_lut = 34'sd20861;
        endcase
    endfunction

endpackage

[src/lsoc_if.sv]
// Interfaces: valid/ready channels for input beams and result items.
interface lsoc_in_if (input logic i_clk);
    import lsoc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lsoc_out_if (input logic i_clk);
    import lsoc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[src/lsoc_datapath.sv]
// Datapath: CORDIC, projection, teammate test and cluster/scan state.
module lsoc_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [19:0]          i_cfg_data,
    input  lsoc_pkg::t_in_item   i_item,
    input  lsoc_pkg::t_cmd       i_cmd,
    output lsoc_pkg::t_sts       o_sts,
    output lsoc_pkg::t_out_item  o_gap_res,
    output lsoc_pkg::t_out_item  o_flush_res,
    output lsoc_pkg::t_out_item  o_sum_res
);
    import lsoc_pkg::*;

    // config
    logic signed [19:0] r_self_x, r_self_y, r_ma_x, r_ma_y, r_mb_x, r_mb_y;
    logic [15:0]        r_heading, r_range_lim;

    // item
    logic [15:0] r_rng, r_ba;
    logic        r_inval, r_end;

    // cordic
    logic signed [17:0] r_cx, r_cy;
    logic signed [33:0] r_cz;
    logic [3:0]         r_it;
    logic               r_busy, r_flip, r_cdone;

    // projection
    logic signed [21:0] r_px, r_py;
    logic signed [47:0] r_da2, r_db2;
    logic               n_clear_mate;

    // scan state
    logic [15:0]        r_prev;
    logic               r_have_prev, r_open, r_gap_emit;
    logic [15:0]        r_cl_rng;
    logic signed [19:0] r_cl_x, r_cl_y;
    logic [15:0]        r_min_rng, r_min_ang;
    logic [15:0]        r_gap_rng;
    logic signed [19:0] r_gap_x, r_gap_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_x <= '0; r_self_y <= '0; r_heading <= '0;
            r_ma_x <= '0; r_ma_y <= '0; r_mb_x <= '0; r_mb_y <= '0;
            r_range_lim <= 16'hFFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SELF_X:    r_self_x    <= i_cfg_data;
                REG_SELF_Y:    r_self_y    <= i_cfg_data;
                REG_HEADING:   r_heading   <= i_cfg_data[15:0];
                REG_MATE_A_X:  r_ma_x      <= i_cfg_data;
                REG_MATE_A_Y:  r_ma_y      <= i_cfg_data;
                REG_MATE_B_X:  r_mb_x      <= i_cfg_data;
                REG_MATE_B_Y:  r_mb_y      <= i_cfg_data;
                REG_RANGE_LIM: r_range_lim <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rng   <= i_item.range_mm;
            r_ba    <= i_item.beam_angle;
            r_inval <= i_item.invalid;
            r_end   <= i_item.scan_end;
        end
    end

    // CORDIC: one rotation per cycle
    logic [15:0]        n_ang, n_res;
    logic               n_flip;
    logic signed [17:0] n_xs, n_ys;
    always_comb begin
        n_ang  = r_heading + r_ba;
        n_flip = (n_ang[15:14] == 2'b01) || (n_ang[15:14] == 2'b10);
        n_res  = n_flip ? (n_ang + 16'h8000) : n_ang;
        n_xs   = r_cx >>> r_it;
        n_ys   = r_cy >>> r_it;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_cdone <= 1'b0;
            r_it    <= '0;
        end else if (i_cmd.cordic_go) begin
            r_busy  <= 1'b1;
            r_cdone <= 1'b0;
            r_it    <= '0;
            r_flip  <= n_flip;
            r_cx    <= CORDIC_X0;
            r_cy    <= '0;
            r_cz    <= {{2{n_res[15]}}, n_res, 16'h0000};
        end else if (r_busy) begin
            if (!r_cz[33]) begin
                r_cx <= r_cx - n_ys; r_cy <= r_cy + n_xs; r_cz <= r_cz - atan_lut(r_it);
            end else begin
                r_cx <= r_cx + n_ys; r_cy <= r_cy - n_xs; r_cz <= r_cz + atan_lut(r_it);
            end
            r_it <= r_it + 4'd1;
            if (r_it == 4'(CORDIC_STEPS - 1)) begin
                r_busy  <= 1'b0;
                r_cdone <= 1'b1;
            end
        end else begin
            r_cdone <= 1'b0;
        end
    end

    // projection
    logic signed [17:0] n_c, n_s, n_cc, n_sc;
    logic signed [34:0] n_mx, n_my;
    always_comb begin
        n_cc = (r_cx > Q15_MAX) ? Q15_MAX : ((r_cx < -Q15_MAX) ? -Q15_MAX : r_cx);
        n_sc = (r_cy > Q15_MAX) ? Q15_MAX : ((r_cy < -Q15_MAX) ? -Q15_MAX : r_cy);
        n_c  = r_flip ? -n_cc : n_cc;
        n_s  = r_flip ? -n_sc : n_sc;
        n_mx = $signed({1'b0, r_rng}) * n_c + 35'sd16384;
        n_my = $signed({1'b0, r_rng}) * n_s + 35'sd16384;
    end

    logic signed [22:0] n_dax, n_day, n_dbx, n_dby;
    always_comb begin
        n_dax = 23'(r_px) - 23'(r_ma_x);
        n_day = 23'(r_py) - 23'(r_ma_y);
        n_dbx = 23'(r_px) - 23'(r_mb_x);
        n_dby = 23'(r_py) - 23'(r_mb_y);
    end

    logic signed [45:0] r_sq_ax, r_sq_ay, r_sq_bx, r_sq_by;
    always_ff @(posedge i_clk) begin
        if (i_cmd.proj) begin
            r_px <= 22'(r_self_x) + 22'(n_mx >>> 15);
            r_py <= 22'(r_self_y) + 22'(n_my >>> 15);
        end
        if (i_cmd.mate_sq) begin
            r_sq_ax <= n_dax * n_dax;
            r_sq_ay <= n_day * n_day;
            r_sq_bx <= n_dbx * n_dbx;
            r_sq_by <= n_dby * n_dby;
        end
        if (i_cmd.decide) begin
            r_da2 <= 48'(r_sq_ax) + 48'(r_sq_ay);
            r_db2 <= 48'(r_sq_bx) + 48'(r_sq_by);
        end
    end

    always_comb n_clear_mate = !(r_da2 < $signed(MATE_RR)) && !(r_db2 < $signed(MATE_RR));

    // cluster and scan state
    logic [15:0]        n_diff;
    logic               n_gap, n_take;
    logic signed [19:0] n_satx, n_saty;
    always_comb begin
        n_diff = (r_rng >= r_prev) ? (r_rng - r_prev) : (r_prev - r_rng);
        n_gap  = r_have_prev && (n_diff > 16'(CLUSTER_GAP_MM));
        n_take = !(r_open && !n_gap) || (r_rng < r_cl_rng);
        n_satx = (r_px > 22'sd524287) ? 20'sd524287 :
                 ((r_px < -22'sd524288) ? 20'sh80000 : r_px[19:0]);
        n_saty = (r_py > 22'sd524287) ? 20'sd524287 :
                 ((r_py < -22'sd524288) ? 20'sh80000 : r_py[19:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_prev <= '0; r_have_prev <= 1'b0; r_open <= 1'b0;
            r_cl_rng <= '0; r_cl_x <= '0; r_cl_y <= '0;
            r_min_rng <= 16'hFFFF; r_min_ang <= '0;
            r_gap_emit <= 1'b0;
        end else if (i_cmd.load) begin
            r_gap_emit <= 1'b0;
        end else if (i_cmd.update) begin
            r_gap_emit <= n_gap && r_open;
            r_gap_rng  <= r_cl_rng;
            r_gap_x    <= r_cl_x;
            r_gap_y    <= r_cl_y;
            if (n_take) begin
                r_cl_rng <= r_rng; r_cl_x <= n_satx; r_cl_y <= n_saty;
            end
            r_open      <= 1'b1;
            r_prev      <= r_rng;
            r_have_prev <= 1'b1;
            if (r_rng < r_min_rng) begin
                r_min_rng <= r_rng; r_min_ang <= r_ba;
            end
        end
    end

    always_comb begin
        o_sts.keep        = !r_inval && (r_rng >= 16'(MIN_RANGE_MM)) && (r_rng <= r_range_lim);
        o_sts.cordic_done = r_cdone;
        o_sts.clear_mate  = n_clear_mate;
        o_sts.gap_emit    = r_gap_emit;
        o_sts.open        = r_open;
        o_sts.scan_end    = r_end;

        // gap result is final unless a flush and summary follow
        o_gap_res = '{KIND_CLUSTER, r_gap_x, r_gap_y, r_gap_rng, 16'h0, 16'h0, !r_end};
        o_flush_res = '{KIND_CLUSTER, r_cl_x, r_cl_y, r_cl_rng, 16'h0, 16'h0, 1'b0};
        o_sum_res = '{KIND_SUMMARY, 20'sd0, 20'sd0, 16'h0, r_min_rng, r_min_ang, 1'b1};
    end

endmodule

[src/lsoc_ctrl.sv]
// Controller: sequences one beam through the datapath and drives the result register.
module lsoc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output lsoc_pkg::t_out_item  o_out_item,
    output lsoc_pkg::t_cmd       o_cmd,
    input  lsoc_pkg::t_sts       i_sts,
    input  lsoc_pkg::t_out_item  i_gap_res,
    input  lsoc_pkg::t_out_item  i_flush_res,
    input  lsoc_pkg::t_out_item  i_sum_res
);
    import lsoc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_ROT, S_PROJ, S_SQ, S_DEC, S_UPD,
        S_GAP, S_FLUSH, S_SUM, S_CLR
    } t_state;

    t_state    r_state;
    logic      r_out_valid;
    t_out_item r_out;
    logic      n_free;
    logic      n_out_load;
    t_out_item n_out_sel;

    assign n_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd = '0;
        o_cmd.load      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.cordic_go = (r_state == S_CHECK) && i_sts.keep;
        o_cmd.proj      = (r_state == S_PROJ);
        o_cmd.mate_sq   = (r_state == S_SQ);
        o_cmd.decide    = (r_state == S_DEC);
        o_cmd.update    = (r_state == S_UPD) && i_sts.clear_mate;
        o_cmd.clear     = (r_state == S_CLR);
    end

    // result to load into the output register this cycle
    always_comb begin
        n_out_load = 1'b0;
        n_out_sel  = i_sum_res;
        unique case (r_state)
            S_GAP: if (i_sts.gap_emit && n_free) begin
                n_out_load = 1'b1;
                n_out_sel  = i_gap_res;
            end
            S_FLUSH: if (i_sts.open && n_free) begin
                n_out_load = 1'b1;
                n_out_sel  = i_flush_res;
            end
            S_SUM:   n_out_load = n_free;
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (n_out_load) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out_sel;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE:  if (i_in_valid) r_state <= S_CHECK;
                S_CHECK: r_state <= i_sts.keep ? S_ROT :
                                    (i_sts.scan_end ? S_FLUSH : S_IDLE);
                S_ROT:   if (i_sts.cordic_done) r_state <= S_PROJ;
                S_PROJ:  r_state <= S_SQ;
                S_SQ:    r_state <= S_DEC;
                S_DEC:   r_state <= S_UPD;
                S_UPD:   r_state <= S_GAP;
                S_GAP: begin
                    if (!i_sts.gap_emit || n_free) begin
                        r_state <= i_sts.scan_end ? S_FLUSH : S_IDLE;
                    end
                end
                S_FLUSH: begin
                    if (!i_sts.open || n_free) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM:   if (n_free) r_state <= S_CLR;
                S_CLR:   r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out))
        else $error("result changed while stalled");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_cmd.update && !o_cmd.clear)
        else $error("state update while idle");
    a_sum_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == KIND_SUMMARY |-> r_out.last)
        else $error("summary without last");

endmodule

[src/lidar_scan_obstacle_clusterer_core.sv]
// Top level: lidar range-jump obstacle clusterer.
//
// Channels: in_ch (sink) takes one beam per transaction: range_mm,
// beam_angle, invalid, scan_end. out_ch (source) gives results: cluster
// representatives (kind 0) and the end-of-scan summary (kind 1), with
// last set on the final result a beam causes (up to three).
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_data write registers 0..7
// (self pose, teammate positions, range limit).
// A dropped beam skips the datapath steps; a kept beam passes through the
// 16-step shared CORDIC rotator followed by projection, squaring and
// the cluster update. One beam is in flight at a time.
// Each result goes out through one output register; a stalled receiver
// holds the sequence at the pending result, the controller waits.
// Reset (synchronous, active low) clears scan state: no open cluster,
// nearest range 65535, and sets the range limit to 65535.
module lidar_scan_obstacle_clusterer_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [19:0]  i_cfg_data,
    lsoc_in_if.sink      in_ch,
    lsoc_out_if.source   out_ch
);
    import lsoc_pkg::*;

    t_cmd      w_cmd;
    t_sts      w_sts;
    t_out_item w_gap, w_flush, w_sum;

    lsoc_datapath u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_item(in_ch.payload), .i_cmd(w_cmd), .o_sts(w_sts),
        .o_gap_res(w_gap), .o_flush_res(w_flush), .o_sum_res(w_sum)
    );

    lsoc_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .i_out_ready(out_ch.ready), .o_out_valid(out_ch.valid),
        .o_out_item(out_ch.payload),
        .o_cmd(w_cmd), .i_sts(w_sts),
        .i_gap_res(w_gap), .i_flush_res(w_flush), .i_sum_res(w_sum)
    );

endmodule

[sim/lidar_scan_obstacle_clusterer_core_test.sv]
// Testbench: self-checking stimulus and result prediction for the lidar scan clusterer.
`timescale 1ns / 1ps

module lidar_scan_obstacle_clusterer_core_test;
    import lsoc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [19:0] i_cfg_data;

    lsoc_in_if  in_ch (i_clk);
    lsoc_out_if out_ch (i_clk);

    lidar_scan_obstacle_clusterer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the registers and the scan state
    // ------------------------------------------------------------------
    logic signed [19:0] pose_x, pose_y, mate_ax, mate_ay, mate_bx, mate_by;
    logic [15:0]        heading, range_lim;

    logic [15:0]        last_kept_range;
    logic               have_last_kept;
    logic               cluster_live;
    logic [15:0]        cluster_near_range;
    logic signed [19:0] cluster_near_x, cluster_near_y;
    logic [15:0]        scan_min_range, scan_min_angle;

    t_out_item pending_results[$];
    int        fail_count = 0;
    int        cycle_count = 0;

    // transaction pacing
    bit idle_on = 1'b1;
    int hold_off_cycles = 0;

    // atan(2^-i), 2^32 units per turn
    longint atan_steps[16] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331, 21354465, 10679838, 5340245,
        2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    function automatic longint clamp_to(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Q1.15 cos/sin of a binary angle
    task automatic rotate_unit(input logic [15:0] ang, output longint c, output longint s);
        logic   flip;
        logic [15:0] a16;
        longint x, y, z, xs, ys;
        flip = 1'b0;
        a16  = ang;
        if (a16 >= 16'd16384 && a16 < 16'd49152) begin
            a16  = a16 + 16'd32768;
            flip = 1'b1;
        end
        z = longint'($signed(a16)) * 65536;
        x = 19898;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - atan_steps[i];
            end else begin
                x = x + ys; y = y - xs; z = z + atan_steps[i];
            end
        end
        x = clamp_to(x, -32767, 32767);
        y = clamp_to(y, -32767, 32767);
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic bit within_mate(longint px, longint py, longint mx, longint my);
        longint dx, dy;
        dx = px - mx;
        dy = py - my;
        return (dx * dx + dy * dy) < longint'(MATE_RADIUS_MM * MATE_RADIUS_MM);
    endfunction

    function automatic t_out_item cluster_result();
        t_out_item o;
        o = '0;
        o.kind           = KIND_CLUSTER;
        o.obstacle_x     = cluster_near_x;
        o.obstacle_y     = cluster_near_y;
        o.obstacle_range = cluster_near_range;
        return o;
    endfunction

    task automatic clear_scan_state();
        last_kept_range    = '0;
        have_last_kept     = 1'b0;
        cluster_live       = 1'b0;
        cluster_near_range = '0;
        cluster_near_x     = '0;
        cluster_near_y     = '0;
        scan_min_range     = 16'hFFFF;
        scan_min_angle     = '0;
    endtask

    // Works out the results one accepted beam causes and queues them.
    task automatic predict_beam(input t_in_item b);
        t_out_item outs[$];
        t_out_item o;
        longint    c, s, px, py, r, jump;
        r = longint'(b.range_mm);
        if (!b.invalid && b.range_mm >= MIN_RANGE_MM && b.range_mm <= range_lim) begin
            rotate_unit(heading + b.beam_angle, c, s);
            px = longint'(pose_x) + ((r * c + 16384) >>> 15);
            py = longint'(pose_y) + ((r * s + 16384) >>> 15);
            if (!within_mate(px, py, mate_ax, mate_ay) &&
                !within_mate(px, py, mate_bx, mate_by)) begin
                jump = r - longint'(last_kept_range);
                if (jump < 0) jump = -jump;
                if (have_last_kept && jump > CLUSTER_GAP_MM) begin
                    if (cluster_live) outs = {outs, cluster_result()};
                    cluster_live = 1'b0;
                end
                if (!cluster_live || b.range_mm < cluster_near_range) begin
                    cluster_near_range = b.range_mm;
                    cluster_near_x     = 20'(clamp_to(px, -524288, 524287));
                    cluster_near_y     = 20'(clamp_to(py, -524288, 524287));
                    cluster_live       = 1'b1;
                end
                last_kept_range = b.range_mm;
                have_last_kept  = 1'b1;
                // a range of 65535 never beats the "none" value
                if (b.range_mm < scan_min_range) begin
                    scan_min_range = b.range_mm;
                    scan_min_angle = b.beam_angle;
                end
            end
        end
        if (b.scan_end) begin
            if (cluster_live) outs = {outs, cluster_result()};
            o = '0;
            o.kind          = KIND_SUMMARY;
            o.nearest_range = scan_min_range;
            o.nearest_angle = scan_min_angle;
            outs = {outs, o};
            clear_scan_state();
        end
        if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
        foreach (outs[k]) pending_results = {pending_results, outs[k]};
    endtask

    // ------------------------------------------------------------------
    // Result receiver: draws a stall per transaction, honours a hold-off
    // ------------------------------------------------------------------
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        wait (i_rst_n === 1'b1);
        forever begin
            stall = idle_on ? $urandom_range(0, 12) : 0;
            if (hold_off_cycles > 0) begin
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
        end
    end

    // Checks each result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want, got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.payload;
            if (pending_results.size() == 0) begin
                $display("%0t: unpredicted result %p", $time, got);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind) begin
                    $display("%0t: kind exp %0d got %0d", $time, want.kind, got.kind);
                    fail_count++;
                end
                if (got.obstacle_x !== want.obstacle_x) begin
                    $display("%0t: obstacle_x exp %0d got %0d", $time,
                             want.obstacle_x, got.obstacle_x);
                    fail_count++;
                end
                if (got.obstacle_y !== want.obstacle_y) begin
                    $display("%0t: obstacle_y exp %0d got %0d", $time,
                             want.obstacle_y, got.obstacle_y);
                    fail_count++;
                end
                if (got.obstacle_range !== want.obstacle_range) begin
                    $display("%0t: obstacle_range exp %0d got %0d", $time,
                             want.obstacle_range, got.obstacle_range);
                    fail_count++;
                end
                if (got.nearest_range !== want.nearest_range) begin
                    $display("%0t: nearest_range exp %0d got %0d", $time,
                             want.nearest_range, got.nearest_range);
                    fail_count++;
                end
                if (got.nearest_angle !== want.nearest_angle) begin
                    $display("%0t: nearest_angle exp %0d got %0d", $time,
                             want.nearest_angle, got.nearest_angle);
                    fail_count++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("** lidar_scan_obstacle_clusterer_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Beam sender: random gap, then holds valid until the transaction
    // ------------------------------------------------------------------
    task automatic send_beam(input logic [15:0] rng, input logic [15:0] ang,
                             input logic inval, input logic last_beam);
        t_in_item b;
        int       gap;
        b.range_mm   = rng;
        b.beam_angle = ang;
        b.invalid    = inval;
        b.scan_end   = last_beam;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= b;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        predict_beam(b);
    endtask

    // Lowers valid, lets the block drain, then writes all eight registers.
    task automatic load_registers(input int sx, input int sy, input int hd,
                                  input int ax, input int ay, input int bx,
                                  input int by, input int lim);
        logic [19:0] vals[8];
        in_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        vals = '{20'(sx), 20'(sy), 20'(hd), 20'(ax), 20'(ay), 20'(bx), 20'(by), 20'(lim)};
        for (int i = 0; i < 8; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        pose_x    = 20'(sx);
        pose_y    = 20'(sy);
        heading   = 16'(hd);
        mate_ax   = 20'(ax);
        mate_ay   = 20'(ay);
        mate_bx   = 20'(bx);
        mate_by   = 20'(by);
        range_lim = 16'(lim);
    endtask

    // One scan: mostly smooth range walks with jumps, some noise.
    task automatic send_scan(input int beams);
        int rng, ang, step;
        rng = $urandom_range(100, 8000);
        ang = $urandom_range(0, 65535);
        for (int i = 0; i < beams; i++) begin
            step = $urandom_range(0, 99);
            if (step < 15)
                rng = rng + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(501, 3000);
            else
                rng = rng + $signed($urandom_range(0, 600)) - 300;
            if (rng < 100 || rng > 65535) rng = $urandom_range(100, 8000);
            ang = (ang + $urandom_range(1, 900)) & 16'hFFFF;
            if (step >= 90)
                send_beam(16'($urandom), 16'($urandom), 1'($urandom), i == beams - 1);
            else
                send_beam(16'(rng), 16'(ang), step < 5, i == beams - 1);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // defaults after reset: origin, heading 0, mates at origin, limit 65535
        send_beam(16'd0,     16'd0,     1'b0, 1'b0);   // below minimum range
        send_beam(16'd99,    16'd100,   1'b0, 1'b0);
        send_beam(16'd449,   16'd200,   1'b0, 1'b0);   // inside teammate radius
        send_beam(16'd450,   16'd0,     1'b0, 1'b0);   // on the radius: kept
        send_beam(16'd800,   16'd16384, 1'b0, 1'b0);
        send_beam(16'd2000,  16'd32768, 1'b0, 1'b0);   // jump closes cluster
        send_beam(16'd2300,  16'd49152, 1'b1, 1'b0);   // invalid
        send_beam(16'd2400,  16'd65535, 1'b0, 1'b0);
        send_beam(16'd65535, 16'd12345, 1'b0, 1'b0);   // sentinel range
        send_beam(16'd500,   16'd40000, 1'b1, 1'b1);   // end on a dropped beam
        send_beam(16'd65535, 16'd8000,  1'b0, 1'b1);   // scan of one sentinel beam
        send_beam(16'd0,     16'd0,     1'b1, 1'b1);   // empty scan
        // mates far away, minimum range and range limit edges
        load_registers(0, 0, 0, 300000, 300000, -300000, -300000, 1000);
        send_beam(16'd100,   16'd24576, 1'b0, 1'b0);
        send_beam(16'd1000,  16'd30000, 1'b0, 1'b0);
        send_beam(16'd1001,  16'd30100, 1'b0, 1'b0);   // over the limit
        send_beam(16'd600,   16'd30200, 1'b0, 1'b0);   // drop of 400: same cluster
        send_beam(16'd601,   16'd30300, 1'b0, 1'b1);
        // pose at both extremes of the field: saturated cluster points
        load_registers(524287, -524288, 0, 0, 0, 0, 0, 65535);
        send_beam(16'd65534, 16'd0,     1'b0, 1'b0);
        send_beam(16'd65000, 16'd49152, 1'b0, 1'b1);
        load_registers(-524288, 524287, 32768, 0, 0, 0, 0, 65535);
        send_beam(16'd65534, 16'd0,     1'b0, 1'b0);
        send_beam(16'd64000, 16'd16384, 1'b0, 1'b1);
    endtask

    task automatic test_config_sweep();
        load_registers(1500, -2200, 16'hFFFF, 1500, -1200, 2500, -2200, 65535);
        repeat (3) send_scan($urandom_range(4, 12));
        load_registers(-1, 1, 8192, -524288, 524287, 524287, -524288, 0);
        repeat (2) send_scan($urandom_range(2, 6));
        load_registers(120000, 80000, 40000, 121000, 80000, 119000, 80500, 5000);
        repeat (3) send_scan($urandom_range(4, 12));
    endtask

    task automatic test_random();
        int done = 0;
        int n;
        while (done < 150) begin
            if ($urandom_range(0, 3) == 0)
                load_registers($signed($urandom_range(0, 20000)) - 10000,
                               $signed($urandom_range(0, 20000)) - 10000,
                               $urandom_range(0, 65535),
                               $signed($urandom_range(0, 20000)) - 10000,
                               $signed($urandom_range(0, 20000)) - 10000,
                               $signed($urandom_range(0, 20000)) - 10000,
                               $signed($urandom_range(0, 20000)) - 10000,
                               $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : 65535);
            idle_on = ($urandom_range(0, 3) != 0);   // some stretches run flat out
            n = $urandom_range(1, 16);
            send_scan(n);
            done += n;
        end
        idle_on = 1'b1;
    endtask

    task automatic test_backpressure();
        load_registers(0, 0, 0, 400000, 400000, -400000, -400000, 65535);
        idle_on         = 1'b0;
        hold_off_cycles = 400;
        repeat (3) send_scan(10);
        idle_on = 1'b1;
    endtask

    initial begin
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        pose_x = '0; pose_y = '0; heading = '0;
        mate_ax = '0; mate_ay = '0; mate_bx = '0; mate_by = '0;
        range_lim = 16'hFFFF;
        clear_scan_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_config_sweep();
        test_backpressure();
        test_random();

        in_ch.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("** lidar_scan_obstacle_clusterer_core: PASSED **");
        else
            $display("** lidar_scan_obstacle_clusterer_core: FAILED **");
        $finish;
    end

endmodule

[sim.f]
src/lsoc_pkg.sv
src/lsoc_if.sv
src/lsoc_datapath.sv
src/lsoc_ctrl.sv
src/lidar_scan_obstacle_clusterer_core.sv
sim/lidar_scan_obstacle_clusterer_core_test.sv
